>>> rtl/assert_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> rtl/hffe_pkg.sv
package hffe_pkg;

   // Build constants.
   localparam int MaxMarkBytes = 4;
   localparam int BufferBytes  = 4096;

   // Marks never exceed four bytes, whatever the build limit says.
   localparam int MarkLimit = (MaxMarkBytes < 4) ? MaxMarkBytes : 4;

   // Field and register widths.
   localparam int ByteW      = 8;
   localparam int MarkLenW   = 3;
   localparam int PatternW   = 32;
   localparam int FixedW     = 13;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 32;
   localparam int WindowW    = 24;
   localparam int FillW      = 2;

   // The frame counter must hold both the size limit and any fixed length.
   localparam int BufCountW = $clog2(BufferBytes + 1);
   localparam int CountW    = (BufCountW > FixedW) ? BufCountW : FixedW;

   // Depth of the word queue between the front and the back.
   localparam int QueueDepth  = 4;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCountW = $clog2(QueueDepth + 1);

   // Configuration register indexes.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_HEADER_LEN   = 3'd0,
      CSR_HEADER_BYTES = 3'd1,
      CSR_FOOTER_LEN   = 3'd2,
      CSR_FOOTER_BYTES = 3'd3,
      CSR_FIXED_LENGTH = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [MarkLenW-1:0] header_len;
      logic [PatternW-1:0] header_bytes;
      logic [MarkLenW-1:0] footer_len;
      logic [PatternW-1:0] footer_bytes;
      logic [FixedW-1:0]   fixed_length;
   } cfg_type;

   // A queue entry is either one finished frame word or a whole header burst.
   typedef enum logic {
      ENTRY_BYTE,
      ENTRY_HEADER
   } entry_kind_type;

   // For a header entry, last marks a burst that closes the frame and good
   // is the verdict for its final word.
   typedef struct packed {
      entry_kind_type   kind;
      logic [ByteW-1:0] data;
      logic             first;
      logic             last;
      logic             good;
      logic             ovf;
   } entry_type;

   // Clip a programmed mark length to the supported number of bytes.
   function automatic logic [MarkLenW-1:0] mark_len(input logic [MarkLenW-1:0] n);
      logic [MarkLenW-1:0] lim;
      lim = MarkLenW'(MarkLimit);
      return (n > lim) ? lim : n;
   endfunction

   // Mask that keeps the low n bytes of a pattern.
   function automatic logic [PatternW-1:0] byte_mask(input logic [MarkLenW-1:0] n);
      logic [PatternW-1:0] m;
      unique case (n)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'h0000_00FF;
         3'd2:    m = 32'h0000_FFFF;
         3'd3:    m = 32'h00FF_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

>>> rtl/hffe_if.sv
// Received byte channel.
interface hffe_req_if;
   logic                          valid;
   logic                          ready;
   logic [hffe_pkg::ByteW-1:0]    rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// Frame word channel.
interface hffe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hffe_pkg::ByteW-1:0]    frame_byte;
   logic                          frame_first;
   logic                          frame_last;
   logic                          frame_good;
   logic                          overflowed;

   modport source (output valid, output frame_byte, output frame_first,
                   output frame_last, output frame_good, output overflowed,
                   input ready);
   modport sink (input valid, input frame_byte, input frame_first,
                 input frame_last, input frame_good, input overflowed,
                 output ready);
endinterface

// Configuration write channel.
interface hffe_csr_if;
   logic                          valid;
   logic                          ready;
   logic [hffe_pkg::CsrIdxW-1:0]  index;
   logic [hffe_pkg::CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/header_footer_frame_extractor.sv
// Header/footer deframer for a received byte stream. One byte is accepted
// per clock whenever the four-word queue between the classifier and the
// output stage has room; the word for a byte is registered in the queue and
// then in the output register. When the configured header is recognized,
// the output stage plays the header out as a burst of up to four words, one
// word per cycle while the receiver is ready. The queue absorbs bytes that
// arrive during the burst, except that a four-byte header followed by
// back-to-back bytes fills the queue and holds the input off. Words stream
// out at one per cycle whenever the receiver is ready. Configuration writes
// are taken on any cycle but must only be issued while the block is idle.
module header_footer_frame_extractor (
   input  logic       clock,
   input  logic       reset,
   hffe_req_if.sink   req_if,
   hffe_rsp_if.source rsp_if,
   hffe_csr_if.sink   csr_if
);

   hffe_pkg::cfg_type   cfg;
   hffe_pkg::entry_type push_entry;
   hffe_pkg::entry_type head;
   logic                push_valid;
   logic                pop;
   logic                queue_full;
   logic                queue_empty;

   // Configuration registers.
   hffe_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // Header hunt and frame byte classification.
   hffe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   hffe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // Burst expansion and output register.
   hffe_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .head   (head),
      .empty  (queue_empty),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

>>> rtl/hffe_csr.sv
module hffe_csr (
   input  logic              clock,
   input  logic              reset,
   hffe_csr_if.sink          csr_if,
   output hffe_pkg::cfg_type cfg
);

   hffe_pkg::cfg_type cfg_ff;
   hffe_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   // Decode the register index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (hffe_pkg::csr_index_type'(csr_if.index))
            hffe_pkg::CSR_HEADER_LEN: begin
               cfg_in.header_len = csr_if.data[hffe_pkg::MarkLenW-1:0];
            end
            hffe_pkg::CSR_HEADER_BYTES: begin
               cfg_in.header_bytes = csr_if.data[hffe_pkg::PatternW-1:0];
            end
            hffe_pkg::CSR_FOOTER_LEN: begin
               cfg_in.footer_len = csr_if.data[hffe_pkg::MarkLenW-1:0];
            end
            hffe_pkg::CSR_FOOTER_BYTES: begin
               cfg_in.footer_bytes = csr_if.data[hffe_pkg::PatternW-1:0];
            end
            hffe_pkg::CSR_FIXED_LENGTH: begin
               cfg_in.fixed_length = csr_if.data[hffe_pkg::FixedW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/hffe_front.sv
module hffe_front (
   input  logic                clock,
   input  logic                reset,
   input  hffe_pkg::cfg_type   cfg,
   hffe_req_if.sink            req_if,
   input  logic                queue_full,
   output logic                push_valid,
   output hffe_pkg::entry_type push_entry
);

   localparam int CountW = hffe_pkg::CountW;

   logic                            collecting_ff, collecting_in;
   logic [hffe_pkg::WindowW-1:0]    window_ff, window_in;
   logic [hffe_pkg::FillW-1:0]      fill_ff, fill_in;
   logic [CountW-1:0]               count_ff, count_in;
   logic [hffe_pkg::PatternW-1:0]   tail_ff, tail_in;

   logic                            accept;
   logic [hffe_pkg::MarkLenW-1:0]   hl, fl, hl_m1, fill_inc;
   logic [CountW-1:0]               cnt_next, fixed_ext;
   logic [hffe_pkg::PatternW-1:0]   tail_next, cand, hdr_mask_m1;
   logic                            hit, end_pre, fb_last, fb_good, fb_ovf;
   logic                            hdr_match, hdr_terminal, hdr_good;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;

   // Frame byte classification: count, footer match, fixed end, size limit.
   always_comb begin
      hl        = hffe_pkg::mark_len(cfg.header_len);
      fl        = hffe_pkg::mark_len(cfg.footer_len);
      hl_m1     = hl - 3'd1;
      fixed_ext = CountW'(cfg.fixed_length);
      cnt_next  = count_ff + CountW'(1);
      tail_next = {tail_ff[hffe_pkg::PatternW-hffe_pkg::ByteW-1:0], req_if.rx_byte};
      hit = (fl != 3'd0) && (cnt_next >= CountW'(fl)) &&
            (((tail_next ^ cfg.footer_bytes) & hffe_pkg::byte_mask(fl)) == '0);
      if (cfg.fixed_length != '0) begin
         end_pre = cnt_next >= fixed_ext;
         fb_good = end_pre && ((fl == 3'd0) || hit);
      end else begin
         end_pre = hit;
         fb_good = hit;
      end
      fb_ovf  = !end_pre && (cnt_next >= CountW'(hffe_pkg::BufferBytes));
      fb_last = end_pre || fb_ovf;
   end

   // Header hunting over the sliding window.
   always_comb begin
      cand         = {window_ff, req_if.rx_byte};
      fill_inc     = {1'b0, fill_ff} + 3'd1;
      hdr_mask_m1  = hffe_pkg::byte_mask(hl_m1);
      hdr_match    = (fill_inc >= hl) &&
                     (((cand ^ cfg.header_bytes) & hffe_pkg::byte_mask(hl)) == '0);
      hdr_terminal = (cfg.fixed_length != '0) && (fixed_ext <= CountW'(hl));
      hdr_good     = (fixed_ext == CountW'(hl)) && (fl == 3'd0);
   end

   // State update and queue entry for an accepted byte.
   always_comb begin
      collecting_in = collecting_ff;
      window_in     = window_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      tail_in       = tail_ff;
      push_valid    = 1'b0;
      push_entry    = '0;
      if (accept) begin
         if (collecting_ff || (hl == 3'd0)) begin
            push_valid       = 1'b1;
            push_entry.kind  = hffe_pkg::ENTRY_BYTE;
            push_entry.data  = req_if.rx_byte;
            push_entry.first = !collecting_ff;
            push_entry.last  = fb_last;
            push_entry.good  = fb_good;
            push_entry.ovf   = fb_ovf;
            if (fb_last) begin
               collecting_in = 1'b0;
               window_in     = '0;
               fill_in       = '0;
               count_in      = '0;
               tail_in       = '0;
            end else begin
               collecting_in = 1'b1;
               count_in      = cnt_next;
               tail_in       = tail_next;
            end
         end else if (!hdr_match) begin
            window_in = cand[hffe_pkg::WindowW-1:0] & hdr_mask_m1[hffe_pkg::WindowW-1:0];
            fill_in   = (fill_inc > hl_m1) ? hl_m1[hffe_pkg::FillW-1:0]
                                           : fill_inc[hffe_pkg::FillW-1:0];
         end else begin
            push_valid       = 1'b1;
            push_entry.kind  = hffe_pkg::ENTRY_HEADER;
            push_entry.first = 1'b1;
            push_entry.last  = hdr_terminal;
            push_entry.good  = hdr_good;
            window_in        = '0;
            fill_in          = '0;
            if (hdr_terminal) begin
               collecting_in = 1'b0;
               count_in      = '0;
               tail_in       = '0;
            end else begin
               collecting_in = 1'b1;
               count_in      = CountW'(hl);
               tail_in       = cfg.header_bytes & hffe_pkg::byte_mask(hl);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         window_ff     <= '0;
         fill_ff       <= '0;
         count_ff      <= '0;
         tail_ff       <= '0;
      end else begin
         collecting_ff <= collecting_in;
         window_ff     <= window_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         tail_ff       <= tail_in;
      end
   end

endmodule

>>> rtl/hffe_queue.sv
module hffe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  hffe_pkg::entry_type push_entry,
   input  logic                pop,
   output hffe_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   localparam int Depth  = hffe_pkg::QueueDepth;
   localparam int PtrW   = hffe_pkg::QueuePtrW;
   localparam int CountW = hffe_pkg::QueueCountW;

   hffe_pkg::entry_type entries_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = count_ff == CountW'(Depth);
   assign empty   = count_ff == '0;
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/hffe_back.sv
module hffe_back (
   input  logic                clock,
   input  logic                reset,
   input  hffe_pkg::cfg_type   cfg,
   input  hffe_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   hffe_rsp_if.source          rsp_if
);

   localparam int ByteW = hffe_pkg::ByteW;

   logic                          valid_ff, valid_in;
   logic [ByteW-1:0]              byte_ff, byte_in;
   logic                          first_ff, first_in;
   logic                          last_ff, last_in;
   logic                          good_ff, good_in;
   logic                          ovf_ff, ovf_in;
   logic [1:0]                    idx_ff, idx_in;

   logic                          load, produce, burst_end;
   logic [hffe_pkg::MarkLenW-1:0] hl_m1_full;
   logic [1:0]                    hl_m1, sel;

   // The output register refills when it is empty or being taken.
   assign load    = !valid_ff || rsp_if.ready;
   assign produce = load && !empty;

   // Build the next word from the queue head, expanding header bursts.
   always_comb begin
      hl_m1_full = hffe_pkg::mark_len(cfg.header_len) - 3'd1;
      hl_m1      = hl_m1_full[1:0];
      sel        = hl_m1 - idx_ff;
      burst_end  = idx_ff == hl_m1;
      valid_in   = load ? !empty : valid_ff;
      byte_in    = byte_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      good_in    = good_ff;
      ovf_in     = ovf_ff;
      idx_in     = idx_ff;
      pop        = 1'b0;
      if (produce) begin
         unique case (head.kind)
            hffe_pkg::ENTRY_BYTE: begin
               byte_in  = head.data;
               first_in = head.first;
               last_in  = head.last;
               good_in  = head.good;
               ovf_in   = head.ovf;
               pop      = 1'b1;
            end
            hffe_pkg::ENTRY_HEADER: begin
               byte_in  = cfg.header_bytes[{sel, 3'b000} +: ByteW];
               first_in = idx_ff == 2'd0;
               last_in  = burst_end && head.last;
               good_in  = burst_end && head.last && head.good;
               ovf_in   = 1'b0;
               pop      = burst_end;
               idx_in   = burst_end ? 2'd0 : idx_ff + 2'd1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      byte_ff  <= byte_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      good_ff  <= good_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.frame_byte  = byte_ff;
   assign rsp_if.frame_first = first_ff;
   assign rsp_if.frame_last  = last_ff;
   assign rsp_if.frame_good  = good_ff;
   assign rsp_if.overflowed  = ovf_ff;

endmodule

>>> rtl/hffe_checker.sv
`include "assert_macros.svh"

module hffe_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [hffe_pkg::ByteW-1:0] rsp_frame_byte,
   input logic                       rsp_frame_first,
   input logic                       rsp_frame_last,
   input logic                       rsp_frame_good,
   input logic                       rsp_overflowed
);

   logic [hffe_pkg::ByteW+3:0] rsp_word;
   logic                       rsp_stall;
   logic                       rsp_mid;
   logic                       rsp_cut;

   // Handshake and payload views of the output channel.
   assign rsp_word  = {rsp_frame_byte, rsp_frame_first, rsp_frame_last,
                       rsp_frame_good, rsp_overflowed};
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_mid   = rsp_valid && !rsp_frame_last;
   assign rsp_cut   = rsp_valid && rsp_overflowed;

   // A stalled word stays put.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // Verdict flags only appear on the closing word of a frame.
   `ASSERT_IMPLIES(a_flags_on_last, clock, reset, rsp_mid, !rsp_frame_good && !rsp_overflowed)

   // An aborted frame is never good, and a frame's first word never overflows.
   `ASSERT_IMPLIES(a_ovf_exclusive, clock, reset, rsp_cut, !(rsp_frame_good || rsp_frame_first))

endmodule

bind header_footer_frame_extractor hffe_checker u_hffe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_frame_byte  (rsp_if.frame_byte),
   .rsp_frame_first (rsp_if.frame_first),
   .rsp_frame_last  (rsp_if.frame_last),
   .rsp_frame_good  (rsp_if.frame_good),
   .rsp_overflowed  (rsp_if.overflowed)
);

>>> sim/hffe_frame_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the deframer, keeps its own copy of the
// registers and of the hunt and frame state, and compares every frame word
// that leaves the block with the oldest predicted word.
module hffe_frame_checker (
   input  logic        clock,
   input  logic        reset,
   hffe_req_if         req,
   hffe_rsp_if         rsp,
   hffe_csr_if         csr,
   output int unsigned mismatches,
   output int unsigned words_owed,
   output int unsigned words_checked,
   output int unsigned frames_closed,
   output int unsigned frames_good,
   output int unsigned frames_cut
);

   typedef struct packed {
      logic [hffe_pkg::ByteW-1:0] data;
      logic                       first;
      logic                       last;
      logic                       good;
      logic                       ovf;
   } frame_word_type;

   // Register copy.
   logic [hffe_pkg::MarkLenW-1:0] cfg_header_len;
   logic [hffe_pkg::PatternW-1:0] cfg_header_bytes;
   logic [hffe_pkg::MarkLenW-1:0] cfg_footer_len;
   logic [hffe_pkg::PatternW-1:0] cfg_footer_bytes;
   logic [hffe_pkg::FixedW-1:0]   cfg_fixed_length;

   // Hunt and frame state.
   logic                          collecting;
   logic [hffe_pkg::WindowW-1:0]  hunt_window;
   logic [hffe_pkg::FillW-1:0]    hunt_fill;
   logic [hffe_pkg::CountW-1:0]   frame_count;
   logic [hffe_pkg::PatternW-1:0] tail_bytes;

   frame_word_type owed_q[$];
   int unsigned    fail_count;
   int unsigned    checked_count;
   int unsigned    closed_count;
   int unsigned    good_count;
   int unsigned    cut_count;

   // Programmed mark lengths above the supported size act as that size.
   function automatic int unsigned clip_mark(input logic [hffe_pkg::MarkLenW-1:0] n);
      return (n > hffe_pkg::MarkLimit) ? hffe_pkg::MarkLimit : n;
   endfunction

   function automatic logic [hffe_pkg::PatternW-1:0] low_bytes(input int unsigned n);
      return (n >= 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * n)) - 32'h1);
   endfunction

   function automatic void restart_hunt();
      collecting  = 1'b0;
      hunt_window = '0;
      hunt_fill   = '0;
      frame_count = '0;
      tail_bytes  = '0;
   endfunction

   // A byte that belongs to a frame after its header, or any byte when no
   // header is set. It decides whether the frame ends here and how.
   function automatic void take_frame_byte(input logic [hffe_pkg::ByteW-1:0] b,
                                           input logic first);
      int unsigned fl;
      logic        hit;
      logic        last;
      logic        good;
      logic        ovf;
      fl          = clip_mark(cfg_footer_len);
      last        = 1'b0;
      good        = 1'b0;
      ovf         = 1'b0;
      frame_count = frame_count + 1'b1;
      tail_bytes  = {tail_bytes[hffe_pkg::PatternW-hffe_pkg::ByteW-1:0], b};
      hit = (fl > 0) && (frame_count >= fl) &&
            (((tail_bytes ^ cfg_footer_bytes) & low_bytes(fl)) == '0);
      if (cfg_fixed_length != '0) begin
         if (frame_count >= cfg_fixed_length) begin
            last = 1'b1;
            good = (fl == 0) || hit;
         end
      end else if (hit) begin
         last = 1'b1;
         good = 1'b1;
      end
      if (!last && frame_count >= hffe_pkg::BufferBytes) begin
         last = 1'b1;
         ovf  = 1'b1;
      end
      owed_q.push_back('{data: b, first: first, last: last, good: good, ovf: ovf});
      if (last) begin
         restart_hunt();
      end else begin
         collecting = 1'b1;
      end
   endfunction

   // One received byte: either part of a frame, or one more step of the
   // header hunt, which may complete the header and release it as a burst.
   function automatic void take_rx_byte(input logic [hffe_pkg::ByteW-1:0] b);
      int unsigned                   hl;
      int unsigned                   i;
      int unsigned                   nf;
      logic [hffe_pkg::PatternW-1:0] cand;
      logic [hffe_pkg::PatternW-1:0] keep;
      logic [hffe_pkg::PatternW-1:0] hb;
      logic                          whole_frame;
      logic                          burst_good;
      hl = clip_mark(cfg_header_len);
      if (collecting) begin
         take_frame_byte(b, 1'b0);
      end else if (hl == 0) begin
         take_frame_byte(b, 1'b1);
      end else begin
         cand = {hunt_window, b};
         if (hunt_fill + 1 < hl || ((cand ^ cfg_header_bytes) & low_bytes(hl)) != '0) begin
            keep        = low_bytes(hl - 1);
            hunt_window = cand[hffe_pkg::WindowW-1:0] & keep[hffe_pkg::WindowW-1:0];
            nf          = (hunt_fill + 1 > hl - 1) ? hl - 1 : hunt_fill + 1;
            hunt_fill   = nf[hffe_pkg::FillW-1:0];
         end else begin
            // A fixed length no longer than the header makes the burst the
            // whole frame.
            whole_frame = (cfg_fixed_length != '0) && (cfg_fixed_length <= hl);
            burst_good  = (cfg_fixed_length == hl) && (clip_mark(cfg_footer_len) == 0);
            for (i = 0; i < hl; i++) begin
               hb = cfg_header_bytes >> (8 * (hl - 1 - i));
               owed_q.push_back('{data: hb[hffe_pkg::ByteW-1:0], first: (i == 0),
                                  last: whole_frame && (i + 1 == hl),
                                  good: whole_frame && (i + 1 == hl) && burst_good,
                                  ovf: 1'b0});
            end
            if (whole_frame) begin
               restart_hunt();
            end else begin
               collecting  = 1'b1;
               hunt_window = '0;
               hunt_fill   = '0;
               frame_count = hl[hffe_pkg::CountW-1:0];
               tail_bytes  = cfg_header_bytes & low_bytes(hl);
            end
         end
      end
   endfunction

   task automatic report(input string msg);
      if (fail_count < 40) begin
         $display("%0t frame check: %s", $time, msg);
      end
      fail_count++;
   endtask

   // Compare one accepted word with the oldest prediction.
   task automatic check_word();
      frame_word_type want;
      if (owed_q.size() == 0) begin
         report($sformatf("word %02h arrived with nothing predicted", rsp.frame_byte));
      end else begin
         want = owed_q.pop_front();
         checked_count++;
         if (rsp.frame_byte !== want.data)
            report($sformatf("frame_byte expected %02h got %02h", want.data, rsp.frame_byte));
         if (rsp.frame_first !== want.first)
            report($sformatf("frame_first expected %b got %b on %02h",
                             want.first, rsp.frame_first, want.data));
         if (rsp.frame_last !== want.last)
            report($sformatf("frame_last expected %b got %b on %02h",
                             want.last, rsp.frame_last, want.data));
         if (rsp.frame_good !== want.good)
            report($sformatf("frame_good expected %b got %b on %02h",
                             want.good, rsp.frame_good, want.data));
         if (rsp.overflowed !== want.ovf)
            report($sformatf("overflowed expected %b got %b on %02h",
                             want.ovf, rsp.overflowed, want.data));
         if (want.last) begin
            closed_count++;
            if (want.good) good_count++;
            if (want.ovf) cut_count++;
         end
      end
   endtask

   // Words are checked before the byte of the same edge is predicted, so a
   // stray word can never pair with a prediction made in its own cycle.
   always @(posedge clock) begin
      if (reset) begin
         cfg_header_len   = '0;
         cfg_header_bytes = '0;
         cfg_footer_len   = '0;
         cfg_footer_bytes = '0;
         cfg_fixed_length = '0;
         restart_hunt();
         owed_q.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               hffe_pkg::CSR_HEADER_LEN:
                  cfg_header_len = csr.data[hffe_pkg::MarkLenW-1:0];
               hffe_pkg::CSR_HEADER_BYTES:
                  cfg_header_bytes = csr.data;
               hffe_pkg::CSR_FOOTER_LEN:
                  cfg_footer_len = csr.data[hffe_pkg::MarkLenW-1:0];
               hffe_pkg::CSR_FOOTER_BYTES:
                  cfg_footer_bytes = csr.data;
               hffe_pkg::CSR_FIXED_LENGTH:
                  cfg_fixed_length = csr.data[hffe_pkg::FixedW-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) check_word();
         if (req.valid && req.ready) take_rx_byte(req.rx_byte);
      end
      words_owed    <= owed_q.size();
      mismatches    <= fail_count;
      words_checked <= checked_count;
      frames_closed <= closed_count;
      frames_good   <= good_count;
      frames_cut    <= cut_count;
   end

endmodule

>>> sim/header_footer_frame_extractor_tb.sv
`timescale 1ns / 100ps

module header_footer_frame_extractor_tb;

   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned TIMEOUT_NS    = 10_000_000;
   localparam int unsigned RANDOM_PHASES = 7;
   localparam int unsigned PHASE_BYTES   = 18;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hffe_req_if req_if();
   hffe_rsp_if rsp_if();
   hffe_csr_if csr_if();

   int unsigned mismatches;
   int unsigned words_owed;
   int unsigned words_checked;
   int unsigned frames_closed;
   int unsigned frames_good;
   int unsigned frames_cut;

   // Current register values, used to shape the byte stream.
   logic [hffe_pkg::MarkLenW-1:0] cur_hl;
   logic [hffe_pkg::PatternW-1:0] cur_hb;
   logic [hffe_pkg::MarkLenW-1:0] cur_fl;
   logic [hffe_pkg::PatternW-1:0] cur_fb;
   logic [hffe_pkg::FixedW-1:0]   cur_fix;

   logic [hffe_pkg::ByteW-1:0] byte_plan[$];
   int unsigned                bytes_sent;
   int unsigned                burst_left;
   int unsigned                settings_count;

   header_footer_frame_extractor DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   hffe_frame_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .rsp           (rsp_if),
      .csr           (csr_if),
      .mismatches    (mismatches),
      .words_owed    (words_owed),
      .words_checked (words_checked),
      .frames_closed (frames_closed),
      .frames_good   (frames_good),
      .frames_cut    (frames_cut)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

   // The receiver switches between stall patterns every so often.
   initial begin : receiver_stalls
      stall_mode_type mode;
      int unsigned    mode_left;
      mode      = STALL_NONE;
      mode_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         case (mode)
            STALL_NONE:  rsp_if.ready <= 1'b1;
            STALL_HALF:  rsp_if.ready <= 1'($urandom_range(0, 1));
            STALL_HEAVY: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_if.ready <= ((mode_left % 16) < 4);
         endcase
      end
   end

   function automatic logic [hffe_pkg::ByteW-1:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[hffe_pkg::ByteW-1:0];
   endfunction

   // Bursts of random length separated by random gaps; some gaps are zero.
   task automatic pace();
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   task automatic send_plan();
      while (byte_plan.size() != 0) begin
         req_if.valid   <= 1'b1;
         req_if.rx_byte <= byte_plan.pop_front();
         do @(posedge clock); while (!req_if.ready);
         bytes_sent++;
         pace();
      end
   endtask

   // Hold the sender until every predicted word is out, then let any byte
   // still in the classifier settle.
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (words_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all five registers back to back; only called while idle.
   task automatic program_regs(input logic [hffe_pkg::MarkLenW-1:0] hl,
                               input logic [hffe_pkg::PatternW-1:0] hb,
                               input logic [hffe_pkg::MarkLenW-1:0] fl,
                               input logic [hffe_pkg::PatternW-1:0] fb,
                               input logic [hffe_pkg::FixedW-1:0]   fix);
      hffe_pkg::csr_index_type       order[5];
      logic [hffe_pkg::CsrDataW-1:0] vals[5];
      int unsigned                   i;
      order = '{hffe_pkg::CSR_HEADER_LEN, hffe_pkg::CSR_HEADER_BYTES,
                hffe_pkg::CSR_FOOTER_LEN, hffe_pkg::CSR_FOOTER_BYTES,
                hffe_pkg::CSR_FIXED_LENGTH};
      vals  = '{hffe_pkg::CsrDataW'(hl), hb, hffe_pkg::CsrDataW'(fl), fb,
                hffe_pkg::CsrDataW'(fix)};
      for (i = 0; i < 5; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= order[i];
         csr_if.data  <= vals[i];
         do @(posedge clock); while (!csr_if.ready);
      end
      csr_if.valid <= 1'b0;
      cur_hl  = hl;
      cur_hb  = hb;
      cur_fl  = fl;
      cur_fb  = fb;
      cur_fix = fix;
      settings_count++;
   endtask

   function automatic logic [hffe_pkg::MarkLenW-1:0] pick_mark_len();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 9) return hffe_pkg::MarkLenW'($urandom_range(5, 7));
      return hffe_pkg::MarkLenW'(((sel - 1) % 4) + 1);
   endfunction

   // Queue one piece of traffic: mostly well-formed frames with random
   // content, plus noise, broken headers and damaged footers.
   task automatic add_random_piece();
      int unsigned                   kind;
      int unsigned                   hlc;
      int unsigned                   flc;
      int unsigned                   body;
      int unsigned                   i;
      logic [hffe_pkg::PatternW-1:0] pat;
      logic [hffe_pkg::ByteW-1:0]    b;
      kind = $urandom_range(0, 9);
      hlc  = (cur_hl > hffe_pkg::MarkLimit) ? hffe_pkg::MarkLimit : cur_hl;
      flc  = (cur_fl > hffe_pkg::MarkLimit) ? hffe_pkg::MarkLimit : cur_fl;
      if (kind == 7) begin
         repeat ($urandom_range(1, 4)) byte_plan.push_back(rand_byte());
      end else if (kind == 8) begin
         // Header cut short by a wrong byte.
         for (i = 0; i + 1 < hlc; i++) begin
            pat = cur_hb >> (8 * (hlc - 1 - i));
            byte_plan.push_back(pat[hffe_pkg::ByteW-1:0]);
         end
         repeat ($urandom_range(1, 3)) byte_plan.push_back(rand_byte());
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) byte_plan.push_back(rand_byte());
         end
         for (i = 0; i < hlc; i++) begin
            pat = cur_hb >> (8 * (hlc - 1 - i));
            byte_plan.push_back(pat[hffe_pkg::ByteW-1:0]);
         end
         if (cur_fix != '0 && cur_fix <= 16) begin
            body = (cur_fix > hlc + flc) ? cur_fix - hlc - flc : 0;
         end else begin
            body = $urandom_range(0, 8);
         end
         repeat (body) byte_plan.push_back(rand_byte());
         for (i = 0; i < flc; i++) begin
            pat = cur_fb >> (8 * (flc - 1 - i));
            b   = pat[hffe_pkg::ByteW-1:0];
            if (kind == 9 && i == 0) b = b ^ (8'h01 << $urandom_range(0, 7));
            byte_plan.push_back(b);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned                   p;
      int unsigned                   phase_start;
      int unsigned                   sel;
      logic                          paused;
      logic [hffe_pkg::MarkLenW-1:0] hl;
      logic [hffe_pkg::MarkLenW-1:0] fl;
      logic [hffe_pkg::FixedW-1:0]   fix;
      bytes_sent     = 0;
      burst_left     = 0;
      settings_count = 0;
      paused         = 1'b0;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= hffe_pkg::CSR_HEADER_LEN;
      csr_if.data    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // No header or fixed length and a one-byte footer: a two-byte frame
      // made of the byte extremes.
      program_regs(3'd0, 32'h0000_0000, 3'd1, 32'h0000_00FF, 13'd0);
      byte_plan = '{8'h00, 8'hFF};
      send_plan();
      drain();

      // The oversized header length is clipped; the header is found after a false
      // start, and a footer equal to the header tail only counts after it.
      program_regs(3'd7, 32'hA55A_00FF, 3'd2, 32'h0000_00FF, 13'd0);
      byte_plan = '{8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h00, 8'hFF};
      send_plan();
      drain();

      // Fixed length equal to the header with no footer: good header-only frame.
      program_regs(3'd3, 32'hFFFF_FFFF, 3'd0, 32'h0000_0000, 13'd3);
      byte_plan = '{8'hFF, 8'hFF, 8'hFF};
      send_plan();
      drain();

      // Fixed length shorter than the header: the header burst alone is the
      // frame and it is bad.
      program_regs(3'd3, 32'h0000_0000, 3'd7, 32'hFFFF_FFFF, 13'd2);
      byte_plan = '{8'h00, 8'h00, 8'h00};
      send_plan();
      drain();

      // Fixed length with a footer: first frame ends on the footer, second not.
      program_regs(3'd2, 32'hFFFF_1234, 3'd2, 32'hFFFF_0D0A, 13'd6);
      byte_plan = '{8'h12, 8'h34, 8'h0D, 8'h0A, 8'h0D, 8'h0A,
                    8'h12, 8'h34, 8'h01, 8'h02, 8'h03, 8'h04};
      send_plan();
      drain();

      // Random settings, each with a run of mixed traffic.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         hl  = pick_mark_len();
         fl  = pick_mark_len();
         sel = $urandom_range(0, 5);
         if (sel <= 2)      fix = '0;
         else if (sel == 3) fix = hffe_pkg::FixedW'($urandom_range(1, 4));
         else if (sel == 4) fix = hffe_pkg::FixedW'($urandom_range(5, 16));
         else               fix = hffe_pkg::FixedW'(hffe_pkg::BufferBytes);
         if (p == 0) fix = hffe_pkg::FixedW'(hffe_pkg::BufferBytes);
         if (p == 1) fix = 13'd1;
         if (hl == '0 && fl == '0 && fix == '0) fl = 3'd1;
         program_regs(hl, $urandom, fl, $urandom, fix);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            add_random_piece();
            send_plan();
            if (p == 3 && !paused && bytes_sent - phase_start > 10) begin
               drain();
               paused = 1'b1;
            end
         end
         drain();
      end

      $display("tb summary: %0d bytes sent over %0d register settings, %0d words checked",
               bytes_sent, settings_count, words_checked);
      $display("tb summary: %0d frames closed, %0d good, %0d cut at the size limit",
               frames_closed, frames_good, frames_cut);
      if (mismatches == 0 && words_owed == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
